// ===== hdl/hrfp_pkg.sv =====
// Shared constants, types and helpers for the H.265 RTP fragmentation packetizer.
package hrfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STAMP_W  = 32;
    localparam int TYPE_W   = 6;
    localparam int CFG_W    = 32;
    localparam int CNT_W    = $clog2(STAMP_W);

    localparam int IN_TDATA_W  = BYTE_W + LEN_W + STAMP_W;
    localparam int OUT_TDATA_W = BYTE_W + STAMP_W;
    localparam int OUT_TUSER_W = 3;

    localparam logic [0:0] CFG_MTU_SIZE = 1'd0;
    localparam logic [0:0] CFG_CYCLE_MS = 1'd1;

    localparam logic [LEN_W-1:0]   MTU_RESET   = 16'd1400;
    localparam logic [STAMP_W-1:0] CYCLE_RESET = 32'd46800000;
    localparam logic [LEN_W-1:0]   MTU_MIN     = 16'd16;
    localparam logic [LEN_W-1:0]   FU_HDR_LEN  = 16'd3;

    localparam logic [BYTE_W-1:0] FU_NAL_BYTE0 = 8'h62;
    localparam logic [BYTE_W-1:0] FU_NAL_BYTE1 = 8'h01;
    localparam logic [BYTE_W-1:0] FU_START_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] FU_END_MASK   = 8'h40;

    typedef logic [TYPE_W-1:0]  t_unit_type;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [STAMP_W-1:0] t_stamp;

    function automatic t_len frag_limit(input t_len mtu);
        t_len m;
        m = (mtu < MTU_MIN) ? MTU_MIN : mtu;
        return m - FU_HDR_LEN;
    endfunction

    function automatic logic is_key_type(input t_unit_type t);
        return t[5:3] == 3'b010;
    endfunction

endpackage

// ===== hdl/hrfp_mod_unit.sv =====
// Bit-serial restoring remainder unit: timestamp modulo wrap period.
module hrfp_mod_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  hrfp_pkg::t_stamp       i_dividend,
    input  hrfp_pkg::t_stamp       i_divisor,
    output logic                   o_done,
    output hrfp_pkg::t_stamp       o_rem
);
    import hrfp_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    t_stamp             r_num;
    t_stamp             r_rem;
    t_stamp             r_div;
    logic [STAMP_W:0]   trial;
    logic [STAMP_W:0]   diff;

    assign trial = {r_rem, r_num[STAMP_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STAMP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[STAMP_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[STAMP_W-1:0];
            end else begin
                r_rem <= trial[STAMP_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/hevc_rtp_fu_packetizer_unit.sv =====
// Top level of the H.265 RTP payload packetizer with fragmentation units.
//
// Input stream: one NAL unit byte per request. tuser marks the first byte of
// a unit; that byte also carries the unit length and millisecond timestamp.
// Output stream: one RTP payload byte per request, tlast on the last byte of
// each payload, tuser carries first-byte, marker and key-start flags, and
// tdata carries the byte and the wrapped timestamp.
// A unit that fits in max(mtu_size,16)-3 bytes passes through as one payload;
// a larger unit loses its two-byte NAL header and is cut into fragments, each
// preceded by a three-byte FU header, plus a header-only end payload when the data ends with a full fragment.
// The block takes one input byte at a time: tready is low from accept until the
// sequencer returns to idle. A plain byte passes through the evaluate and data
// states; a fragment boundary adds the FU header states. The first byte of a unit
// first waits for the bit-serial timestamp modulo, one remainder bit per cycle.
// Reset clears the sequencer state and restores mtu_size 1400, cycle_ms 46800000.
// A stalled receiver holds the output register and the sequencer waits;
// no byte is dropped. Write configuration only while idle.
module hevc_rtp_fu_packetizer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte, [23:8] unit_length, [55:24] stamp_ms
    input  logic [hrfp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] unit_start
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] payload_byte, [39:8] rtp_stamp
    output logic [hrfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] packet_first, [1] marker_bit, [2] key_start
    output logic [hrfp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [hrfp_pkg::CFG_W-1:0]          i_cfg_data
);
    import hrfp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_HDR0 = 3'd3;
    localparam logic [2:0] ST_HDR1 = 3'd4;
    localparam logic [2:0] ST_HDR2 = 3'd5;
    localparam logic [2:0] ST_DATA = 3'd6;

    logic [2:0]     r_state;
    t_len           r_mtu;
    t_stamp         r_cycle;

    logic [BYTE_W-1:0] r_byte;
    t_len           r_len_in;

    t_unit_type     r_unit_type;
    logic           r_frag;
    t_len           r_byte_pos;
    t_len           r_total_len;
    t_len           r_frag_left;
    logic           r_first;
    logic           r_final;
    t_stamp         r_held_stamp;

    logic           r_sel_s;
    logic           r_sel_e;
    logic           r_tail;
    logic           r_dfirst;
    logic           r_dlast;

    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_byte;
    t_stamp            r_m_stamp;
    logic              r_m_first;
    logic              r_m_last;
    logic              r_m_marker;
    logic              r_m_key;

    logic           accept;
    logic           o_free;
    logic           mod_start;
    logic           mod_done;
    t_stamp         mod_rem;
    t_len           lim;
    t_len           rem_len;
    logic           key_type;

    logic              emit_en;
    logic [BYTE_W-1:0] e_byte;
    logic              e_first;
    logic              e_last;
    logic              e_marker;
    logic              e_key;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_free        = !r_m_valid || m_axis_tready;
    assign mod_start     = accept && s_axis_tuser;
    assign lim           = frag_limit(r_mtu);
    assign rem_len       = r_total_len - r_byte_pos;
    assign key_type      = is_key_type(r_unit_type);

    hrfp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (s_axis_tdata[IN_TDATA_W-1:BYTE_W+LEN_W]),
        .i_divisor  (r_cycle),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        emit_en  = 1'b0;
        e_byte   = r_byte;
        e_first  = 1'b0;
        e_last   = 1'b0;
        e_marker = r_final;
        e_key    = r_first && key_type;
        unique case (r_state)
            ST_HDR0: begin
                emit_en = 1'b1;
                e_byte  = FU_NAL_BYTE0;
                e_first = 1'b1;
            end
            ST_HDR1: begin
                emit_en = 1'b1;
                e_byte  = FU_NAL_BYTE1;
            end
            ST_HDR2: begin
                emit_en = 1'b1;
                e_byte  = (r_sel_s ? FU_START_MASK : '0) | (r_sel_e ? FU_END_MASK : '0)
                        | {2'b00, r_unit_type};
                e_last  = r_tail;
            end
            ST_DATA: begin
                emit_en = 1'b1;
                if (r_frag) begin
                    e_last = (r_frag_left == t_len'(1));
                end else begin
                    e_first  = r_dfirst;
                    e_last   = r_dlast;
                    e_marker = 1'b1;
                    e_key    = key_type;
                end
            end
            default: begin
                emit_en = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu   <= MTU_RESET;
            r_cycle <= CYCLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MTU_SIZE: r_mtu   <= i_cfg_data[LEN_W-1:0];
                CFG_CYCLE_MS: r_cycle <= i_cfg_data[STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_unit_type  <= '0;
            r_frag       <= 1'b0;
            r_byte_pos   <= '0;
            r_total_len  <= '0;
            r_frag_left  <= '0;
            r_first      <= 1'b1;
            r_final      <= 1'b0;
            r_held_stamp <= '0;
            r_sel_s      <= 1'b0;
            r_sel_e      <= 1'b0;
            r_tail       <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= s_axis_tuser ? ST_MOD : ST_EVAL;
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        r_held_stamp <= mod_rem;
                        r_unit_type  <= r_byte[TYPE_W:1];
                        r_total_len  <= r_len_in;
                        r_frag       <= r_len_in > lim;
                        r_byte_pos   <= '0;
                        r_frag_left  <= '0;
                        r_first      <= 1'b1;
                        r_final      <= 1'b0;
                        r_state      <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (r_byte_pos >= r_total_len) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_byte_pos <= r_byte_pos + 1'b1;
                        if (!r_frag) begin
                            r_state <= ST_DATA;
                        end else if (r_byte_pos < t_len'(2)) begin
                            r_state <= ST_IDLE;
                        end else if (r_frag_left == '0) begin
                            r_tail <= 1'b0;
                            if (rem_len < lim) begin
                                r_final     <= 1'b1;
                                r_frag_left <= rem_len;
                                r_sel_s     <= 1'b0;
                                r_sel_e     <= 1'b1;
                            end else begin
                                r_final     <= 1'b0;
                                r_frag_left <= lim;
                                r_sel_s     <= r_first;
                                r_sel_e     <= 1'b0;
                            end
                            r_state <= ST_HDR0;
                        end else begin
                            r_state <= ST_DATA;
                        end
                    end
                end
                ST_HDR0: begin
                    if (o_free) begin
                        r_state <= ST_HDR1;
                    end
                end
                ST_HDR1: begin
                    if (o_free) begin
                        r_state <= ST_HDR2;
                    end
                end
                ST_HDR2: begin
                    if (o_free) begin
                        r_state <= r_tail ? ST_IDLE : ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (o_free) begin
                        if (r_frag) begin
                            r_frag_left <= r_frag_left - 1'b1;
                            if (r_frag_left == t_len'(1) && !r_final) begin
                                r_first <= 1'b0;
                            end
                        end
                        if (r_frag && r_frag_left == t_len'(1) && !r_final &&
                            r_byte_pos == r_total_len) begin
                            r_final <= 1'b1;
                            r_sel_s <= 1'b0;
                            r_sel_e <= 1'b1;
                            r_tail  <= 1'b1;
                            r_state <= ST_HDR0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // capture request and data-byte flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte     <= s_axis_tdata[BYTE_W-1:0];
            r_len_in   <= s_axis_tdata[BYTE_W+LEN_W-1:BYTE_W];
        end
        if (r_state == ST_EVAL) begin
            r_dfirst <= (r_byte_pos == '0);
            r_dlast  <= (rem_len == t_len'(1));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_free) begin
            r_m_valid <= emit_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && emit_en) begin
            r_m_byte   <= e_byte;
            r_m_stamp  <= r_held_stamp;
            r_m_first  <= e_first;
            r_m_last   <= e_last;
            r_m_marker <= e_marker;
            r_m_key    <= e_key;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_stamp, r_m_byte};
    assign m_axis_tuser  = {r_m_key, r_m_marker, r_m_first};
    assign m_axis_tlast  = r_m_last;

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == ST_MOD)
        else $error("remainder finished outside its wait state");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos <= r_total_len)
        else $error("byte position ran past unit length");

    a_tail_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR0 && r_tail) |-> (r_final && r_sel_e && !r_sel_s))
        else $error("trailing FU header without end flag");

    a_hdr_start_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR0 && o_free && r_sel_s) |=> (r_m_valid && r_m_first))
        else $error("start fragment header not loaded as payload start");

endmodule

// ===== tb/tb_hevc_rtp_fu_packetizer_unit.sv =====
// Testbench for the H.265 RTP fragmentation packetizer: directed and random units, scoreboarded.
module tb_hevc_rtp_fu_packetizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hrfp_pkg::*;

    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              marker;
        logic              key;
        t_stamp            stamp;
    } t_payload;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [0:0]             i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    hevc_rtp_fu_packetizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // packetizer state mirror
    t_len       mtu_reg;
    t_stamp     cycle_reg;
    t_unit_type cur_type;
    logic       fragmenting;
    t_len       byte_pos;
    t_len       unit_len;
    t_len       frag_left;
    logic       first_frag;
    logic       final_frag;
    t_stamp     unit_stamp;

    t_payload expected_payload_q[$];
    int       mismatch_count = 0;
    logic     tx_idle = 1'b1;
    logic     rx_idle = 1'b1;
    int       rx_stall = 0;
    int       hold_cycles = 0;
    t_payload got;
    t_payload want;

    function automatic t_len fu_data_limit();
        return ((mtu_reg < MTU_MIN) ? MTU_MIN : mtu_reg) - FU_HDR_LEN;
    endfunction

    function automatic logic is_irap_type(t_unit_type t);
        return (t >= 6'd16) && (t <= 6'd23);
    endfunction

    function automatic void push_payload(logic [BYTE_W-1:0] b, logic first, logic last,
                                         logic marker, logic key);
        t_payload r;
        r.data   = b;
        r.first  = first;
        r.last   = last;
        r.marker = marker;
        r.key    = key;
        r.stamp  = unit_stamp;
        expected_payload_q.insert(expected_payload_q.size(), r);
    endfunction

    function automatic void push_fu_header(logic [BYTE_W-1:0] sel, logic last, logic marker,
                                           logic key);
        push_payload(FU_NAL_BYTE0, 1'b1, 1'b0, marker, key);
        push_payload(FU_NAL_BYTE1, 1'b0, 1'b0, marker, key);
        push_payload(sel | {2'b00, cur_type}, 1'b0, last, marker, key);
    endfunction

    function automatic void packetize_byte(logic [BYTE_W-1:0] b, logic start, t_len len,
                                           t_stamp st);
        t_len            p;
        t_len            lim;
        t_len            rem;
        logic [BYTE_W-1:0] sel;
        logic            key;
        if (start) begin
            cur_type    = b[6:1];
            unit_len    = len;
            unit_stamp  = (cycle_reg != 0) ? st % cycle_reg : st;
            fragmenting = len > fu_data_limit();
            byte_pos    = '0;
            frag_left   = '0;
            first_frag  = 1'b1;
            final_frag  = 1'b0;
        end
        p = byte_pos;
        if (p >= unit_len) return;
        byte_pos = p + 1'b1;
        if (!fragmenting) begin
            push_payload(b, p == 0, byte_pos == unit_len, 1'b1, is_irap_type(cur_type));
            return;
        end
        // drop the NAL header
        if (p < 2) return;
        if (frag_left == 0) begin
            lim = fu_data_limit();
            rem = unit_len - p;
            if (rem < lim) begin
                final_frag = 1'b1;
                frag_left  = rem;
                sel        = FU_END_MASK;
            end else begin
                final_frag = 1'b0;
                frag_left  = lim;
                sel        = first_frag ? FU_START_MASK : '0;
            end
            push_fu_header(sel, 1'b0, final_frag, first_frag && is_irap_type(cur_type));
        end
        key = first_frag && is_irap_type(cur_type);
        frag_left--;
        push_payload(b, 1'b0, frag_left == 0, final_frag, key);
        if (frag_left == 0 && !final_frag) begin
            first_frag = 1'b0;
            if (byte_pos == unit_len) begin
                final_frag = 1'b1;
                push_fu_header(FU_END_MASK, 1'b1, 1'b1, 1'b0);
            end
        end
    endfunction

    function automatic void reset_packetizer();
        mtu_reg     = MTU_RESET;
        cycle_reg   = CYCLE_RESET;
        cur_type    = '0;
        fragmenting = 1'b0;
        byte_pos    = '0;
        unit_len    = '0;
        frag_left   = '0;
        first_frag  = 1'b1;
        final_frag  = 1'b0;
        unit_stamp  = '0;
    endfunction

    // receiver: long hold first, then per-result stall
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else if (rx_stall > 0) begin
                m_axis_tready = 1'b0;
                rx_stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data   = m_axis_tdata[BYTE_W-1:0];
            got.stamp  = m_axis_tdata[BYTE_W +: STAMP_W];
            got.first  = m_axis_tuser[0];
            got.marker = m_axis_tuser[1];
            got.key    = m_axis_tuser[2];
            got.last   = m_axis_tlast;
            rx_stall   = rx_idle ? int'($urandom_range(0, 8)) : 0;
            if (expected_payload_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected payload byte %h stamp %h", got.data, got.stamp);
                mismatch_count++;
            end else begin
                want = expected_payload_q.pop_front();
                if (got.data !== want.data || got.first !== want.first ||
                    got.last !== want.last || got.marker !== want.marker ||
                    got.key !== want.key || got.stamp !== want.stamp) begin
                    if (mismatch_count < 10)
                        $display("mismatch: exp byte %h first %b last %b marker %b key %b ",
                                 "stamp %h, got byte %h first %b last %b marker %b key %b ",
                                 "stamp %h",
                                 want.data, want.first, want.last, want.marker, want.key,
                                 want.stamp, got.data, got.first, got.last, got.marker,
                                 got.key, got.stamp);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start, input t_len len,
                             input t_stamp st);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 8)) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {st, len, b};
        s_axis_tuser  = start;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        packetize_byte(b, start, len, st);
        @(negedge i_clk);
    endtask

    task automatic send_tail(input int n);
        for (int i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                      t_len'($urandom_range(0, 16'hFFFF)), $urandom());
    endtask

    task automatic send_unit(input logic [BYTE_W-1:0] first_b, input t_len len, input int nbytes,
                             input t_stamp st);
        send_byte(first_b, 1'b1, len, st);
        send_tail(nbytes - 1);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (expected_payload_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [CFG_W-1:0] value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_MTU_SIZE)
            mtu_reg = value[LEN_W-1:0];
        else
            cycle_reg = value;
    endtask

    task automatic test_pass_through();
        send_tail(1);
        send_unit(8'hA6, 16'd1, 1, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1, 16'd3, 32'd0);
        send_byte(8'hFF, 1'b0, 16'd0, 32'd0);
        send_byte(8'h55, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        send_unit(8'h20, 16'd2, 4, $urandom());
        send_unit(8'h22, 16'd0, 2, $urandom());
        send_unit(8'h24, 16'hFFFF, 3, 32'd0);
        send_unit(8'hFF, 16'd2, 2, $urandom());
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_CYCLE_MS, 32'd0);
        send_unit(8'h02, 16'd1, 1, $urandom());
        write_reg(CFG_CYCLE_MS, 32'd1);
        send_unit(8'h04, 16'd1, 1, $urandom());
        write_reg(CFG_CYCLE_MS, 32'hFFFF_FFFF);
        send_unit(8'h06, 16'd1, 1, 32'hFFFF_FFFF);
        send_unit(8'h08, 16'd1, 1, 32'hFFFF_FFFE);
        write_reg(CFG_MTU_SIZE, 32'd0);
        send_unit(8'h20, 16'd14, 14, $urandom());
        write_reg(CFG_MTU_SIZE, 32'hFFFF);
        send_unit(8'h2E, 16'd20, 20, $urandom());
    endtask

    task automatic test_fragment_cases();
        write_reg(CFG_MTU_SIZE, 32'd16);
        write_reg(CFG_CYCLE_MS, $urandom());
        send_unit(8'h26, 16'd15, 15, $urandom());
        send_unit(8'h80, 16'd28, 28, $urandom());
        write_reg(CFG_MTU_SIZE, 32'd20);
        send_unit(8'h21, 16'd40, 10, $urandom());
        write_reg(CFG_MTU_SIZE, 32'd16);
        write_reg(CFG_CYCLE_MS, 32'd7);
        send_tail(30);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MTU_SIZE, 32'd16);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        @(posedge i_clk);
        hold_cycles = 300;
        @(negedge i_clk);
        send_unit(8'h2C, 16'd60, 60, $urandom());
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic send_random_unit(inout int items);
        t_len       lim;
        t_len       len;
        int         kind;
        int         pick;
        int         nbytes;
        t_unit_type ty;
        logic       hi;
        logic       lo;
        lim  = fu_data_limit();
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (lim > 40 || pick < 3)
            len = t_len'($urandom_range(1, (lim > 40) ? 40 : lim));
        else if (pick < 6)
            len = t_len'(2 + lim * $urandom_range(1, 3) - $urandom_range(0, 1));
        else
            len = t_len'($urandom_range(lim + 1, 3 * lim + 4));
        ty = ($urandom_range(0, 9) < 4) ? t_unit_type'($urandom_range(16, 23))
                                        : t_unit_type'($urandom_range(0, 63));
        hi = 1'($urandom_range(0, 1));
        lo = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) tx_idle = !tx_idle;
        if ($urandom_range(0, 7) == 0) rx_idle = !rx_idle;
        if (kind < 80) begin
            nbytes = len;
        end else if (kind < 90) begin
            // truncate; the next unit start restarts it
            nbytes = (len > 1) ? int'($urandom_range(1, len - 1)) : 1;
        end else if (kind < 95) begin
            nbytes = int'(len + $urandom_range(1, 3));
        end else if (kind < 98) begin
            len    = '0;
            nbytes = $urandom_range(1, 2);
        end else begin
            send_tail($urandom_range(1, 3));
            return;
        end
        send_unit({hi, ty, lo}, len, nbytes, $urandom());
        items += (nbytes < len) ? nbytes : len;
    endtask

    task automatic test_random();
        int         items;
        logic [CFG_W-1:0] mtu;
        logic [CFG_W-1:0] cyc;
        for (int ph = 0; ph < 7; ph++) begin
            mtu = (ph == 0) ? 32'd16 : (ph == 5) ? 32'hFFFF :
                  (ph == 3) ? $urandom_range(0, 15) : $urandom_range(17, 40);
            cyc = (ph == 1) ? 32'd1 : (ph == 2) ? 32'hFFFF_FFFF : $urandom();
            write_reg(CFG_MTU_SIZE, mtu);
            write_reg(CFG_CYCLE_MS, cyc);
            tx_idle = (ph % 3) != 1;
            rx_idle = (ph % 3) != 2;
            items = 0;
            while (items < 12) send_random_unit(items);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        reset_packetizer();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_pass_through();
        test_register_extremes();
        test_fragment_cases();
        test_backpressure();
        test_random();
        drain();
        mismatch_count += expected_payload_q.size();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hrfp_pkg.sv
hdl/hrfp_mod_unit.sv
hdl/hevc_rtp_fu_packetizer_unit.sv
tb/tb_hevc_rtp_fu_packetizer_unit.sv
